// ===== design/dls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dls_pkg;

  localparam int NUM_LEVELS_DEF = 256;
  localparam int PWM_BITS_DEF   = 10;

  localparam int LEVEL_W     = 8;
  localparam int PWM_FIELD_W = 10;
  localparam int ADDR_W      = LEVEL_W + 1;  // level index plus one, for step up past the top

  localparam logic [2:0] MODE_TOGGLE   = 3'd0;
  localparam logic [2:0] MODE_UP       = 3'd1;
  localparam logic [2:0] MODE_DOWN     = 3'd2;
  localparam logic [2:0] MODE_SET      = 3'd3;
  localparam logic [2:0] MODE_WRITE    = 3'd4;
  localparam logic [2:0] MODE_REAPPLY  = 3'd5;
  localparam logic [2:0] MODE_DEFAULTS = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_MAX   = 2'd2;
  localparam logic [1:0] ST_OFF   = 2'd3;

  typedef struct packed {
    logic [2:0]             mode;
    logic                   set_on;
    logic [LEVEL_W-1:0]     set_level;
    logic [PWM_FIELD_W-1:0] set_pwm;
    logic                   pwm_given;
    logic [LEVEL_W-1:0]     table_index;
    logic [PWM_FIELD_W-1:0] table_value;
  } dls_in_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   light_on;
    logic [LEVEL_W-1:0]     light_level;
    logic [PWM_FIELD_W-1:0] light_pwm;
  } dls_out_t;

  // table access request from the sequencer
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [LEVEL_W-1:0] wr_addr;
  } dls_tbl_req_t;

endpackage

`default_nettype wire

// ===== design/dimmer_level_stepper_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Dimmer level stepper: light state (on flag, level, PWM duty) plus a table
// of PWM duty per level, driven one command word at a time.
//
// Command channel: a word in cmd is taken at a rising edge with start high
// and busy low. busy stays high until the command is finished.
// Result channel: done is high for exactly one cycle; result then holds the
// status and the light state after the command. There is no back pressure,
// the receiver must take the word in that cycle.
// Config channel: cfg_data (off level) is written when cfg_valid and
// cfg_ready are both high; cfg_ready follows !busy.
// Toggle, table write, unused code and step down while off finish straight
// from the accept edge; commands with one table read pass through S_RD and
// S_EVAL; set-with-PWM and re-apply that miss the exact match walk the table
// one entry per cycle through the single table read port, then read the duty
// of the chosen level. One command is in flight at a time; a new one may
// start in the cycle done is shown.
// Reset: light off, level 0, duty 0, off level 0. Table entries carry valid
// flags cleared by reset, so the table reads as all zero at once; there is
// no clearing pass.
module dimmer_level_stepper_core import dls_pkg::*; #(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF,
  parameter int PWM_BITS   = PWM_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire dls_in_t            cmd,
  output logic                    done,
  output dls_out_t                result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LEVEL_W-1:0] cfg_data
);

  logic [LEVEL_W-1:0]  off_level;
  dls_tbl_req_t        tbl_req;
  logic [PWM_BITS-1:0] tbl_wdata;
  logic [PWM_BITS-1:0] tbl_rdata;

  // config is only written between commands
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_level <= '0;
    end else if (cfg_valid && cfg_ready) begin
      off_level <= cfg_data;
    end
  end

  // sequencer with the shared compare unit and the light state
  dls_ctrl #(
    .NUM_LEVELS (NUM_LEVELS),
    .PWM_BITS   (PWM_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .off_level (off_level),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .tbl_req   (tbl_req),
    .tbl_wdata (tbl_wdata),
    .tbl_rdata (tbl_rdata)
  );

  // level table: RAM with per-entry valid flags, one read and one write per cycle
  dls_table #(
    .NUM_LEVELS (NUM_LEVELS),
    .PWM_BITS   (PWM_BITS)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .req   (tbl_req),
    .wdata (tbl_wdata),
    .rdata (tbl_rdata)
  );

endmodule

`default_nettype wire

// ===== design/dls_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dls_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/dls_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dls_table import dls_pkg::*; #(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF,
  parameter int PWM_BITS   = PWM_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dls_tbl_req_t        req,
  input  wire logic [PWM_BITS-1:0] wdata,
  output logic      [PWM_BITS-1:0] rdata
);

  localparam int AW = $clog2(NUM_LEVELS);

  logic [NUM_LEVELS-1:0] valid;
  logic                  rd_zero;
  logic                  wr_in_range;
  logic                  rd_in_range;
  logic [PWM_BITS-1:0]   ram_q;

  assign wr_in_range = {1'b0, req.wr_addr} < ADDR_W'(NUM_LEVELS);
  assign rd_in_range = req.rd_addr < ADDR_W'(NUM_LEVELS);

  // an entry never written reads as zero; out of range reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      rd_zero <= 1'b1;
    end else begin
      if (req.wr_en && wr_in_range) begin
        valid[req.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_zero <= rd_in_range ? !valid[req.rd_addr[AW-1:0]] : 1'b1;
      end
    end
  end

  dls_ram #(
    .WIDTH (PWM_BITS),
    .DEPTH (NUM_LEVELS)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en && wr_in_range),
    .waddr (req.wr_addr[AW-1:0]),
    .wdata (wdata),
    .re    (req.rd_en),
    .raddr (req.rd_addr[AW-1:0]),
    .rdata (ram_q)
  );

  assign rdata = rd_zero ? '0 : ram_q;

endmodule

`default_nettype wire

// ===== design/dls_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dls_ctrl import dls_pkg::*; #(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF,
  parameter int PWM_BITS   = PWM_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire dls_in_t             cmd,
  input  wire logic [LEVEL_W-1:0]  off_level,
  output logic                     busy,
  output logic                     done,
  output dls_out_t                 result,
  output dls_tbl_req_t             tbl_req,
  output logic      [PWM_BITS-1:0] tbl_wdata,
  input  wire logic [PWM_BITS-1:0] tbl_rdata
);

  localparam int AW = $clog2(NUM_LEVELS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_WALK = 2'd3;

  // what to do with the word read in S_EVAL
  localparam logic [1:0] K_TAKE  = 2'd0;
  localparam logic [1:0] K_CHECK = 2'd1;
  localparam logic [1:0] K_MATCH = 2'd2;

  logic [1:0]          state;
  logic [1:0]          kind;
  logic [1:0]          fail_status;
  logic                arg_on;
  logic [ADDR_W-1:0]   arg_level;
  logic [PWM_BITS-1:0] arg_pwm;
  logic                found_on;
  logic [LEVEL_W-1:0]  found_level;
  logic [AW-1:0]       walk_idx;
  logic                is_on;
  logic [LEVEL_W-1:0]  cur_level;
  logic [PWM_BITS-1:0] cur_pwm;
  logic [1:0]          status;

  // shared compare unit: table word against the reference duty
  logic d_zero, d_eq, d_gt, qualifies, walk_last;

  assign d_zero    = (tbl_rdata == '0);
  assign d_eq      = (tbl_rdata == arg_pwm);
  assign d_gt      = (tbl_rdata > arg_pwm);
  assign qualifies = !d_zero && !d_gt;
  assign walk_last = (walk_idx == AW'(NUM_LEVELS - 1));

  assign busy = (state != S_IDLE);

  always_comb begin
    tbl_req.rd_en   = 1'b0;
    tbl_req.rd_addr = arg_level;
    tbl_req.wr_en   = (state == S_IDLE) && start && (cmd.mode == MODE_WRITE);
    tbl_req.wr_addr = cmd.table_index;
    unique case (state)
      S_RD: begin
        tbl_req.rd_en = 1'b1;
      end
      S_EVAL: begin
        tbl_req.rd_en   = (kind == K_MATCH) && !d_eq;
        tbl_req.rd_addr = '0;
      end
      S_WALK: begin
        tbl_req.rd_en   = qualifies && !walk_last;
        tbl_req.rd_addr = ADDR_W'(walk_idx) + ADDR_W'(1);
      end
      default: begin
        tbl_req.rd_en = 1'b0;
      end
    endcase
  end

  assign tbl_wdata = PWM_BITS'(cmd.table_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      is_on     <= 1'b0;
      cur_level <= '0;
      cur_pwm   <= '0;
      status    <= ST_OK;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            status <= ST_OK;
            unique case (cmd.mode)
              MODE_TOGGLE: begin
                is_on <= !is_on;
                done  <= 1'b1;
              end
              MODE_UP: begin
                arg_on <= 1'b1;
                state  <= S_RD;
                if (!is_on) begin
                  arg_level <= '0;
                  kind      <= K_TAKE;
                end else begin
                  arg_level   <= {1'b0, cur_level} + ADDR_W'(1);
                  kind        <= K_CHECK;
                  fail_status <= ST_MAX;
                end
              end
              MODE_DOWN: begin
                if (!is_on) begin
                  status <= ST_OFF;
                  done   <= 1'b1;
                end else begin
                  kind  <= K_TAKE;
                  state <= S_RD;
                  if (cur_level == '0) begin
                    arg_on    <= 1'b0;
                    arg_level <= {1'b0, off_level};
                  end else begin
                    arg_on    <= 1'b1;
                    arg_level <= {1'b0, cur_level - LEVEL_W'(1)};
                  end
                end
              end
              MODE_SET: begin
                arg_on      <= cmd.set_on;
                arg_level   <= {1'b0, cmd.set_level};
                arg_pwm     <= PWM_BITS'(cmd.set_pwm);
                kind        <= cmd.pwm_given ? K_MATCH : K_CHECK;
                fail_status <= ST_RANGE;
                state       <= S_RD;
              end
              MODE_REAPPLY: begin
                arg_on    <= is_on;
                arg_level <= {1'b0, cur_level};
                arg_pwm   <= cur_pwm;
                kind      <= K_MATCH;
                state     <= S_RD;
              end
              MODE_DEFAULTS: begin
                arg_on    <= 1'b0;
                arg_level <= {1'b0, off_level};
                kind      <= K_TAKE;
                state     <= S_RD;
              end
              default: begin
                // table write (issued combinationally) and the unused code
                done <= 1'b1;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          unique case (kind)
            K_MATCH: begin
              if (d_eq) begin
                is_on     <= arg_on;
                cur_level <= arg_level[LEVEL_W-1:0];
                cur_pwm   <= arg_pwm;
                done      <= 1'b1;
                state     <= S_IDLE;
              end else begin
                // walk starts at entry 0, read issued this cycle
                found_on    <= 1'b0;
                found_level <= off_level;
                walk_idx    <= '0;
                state       <= S_WALK;
              end
            end
            K_CHECK: begin
              if (d_zero) begin
                status <= fail_status;
              end else begin
                is_on     <= arg_on;
                cur_level <= arg_level[LEVEL_W-1:0];
                cur_pwm   <= tbl_rdata;
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
            default: begin
              is_on     <= arg_on;
              cur_level <= arg_level[LEVEL_W-1:0];
              cur_pwm   <= tbl_rdata;
              done      <= 1'b1;
              state     <= S_IDLE;
            end
          endcase
        end
        S_WALK: begin
          if (qualifies) begin
            found_on    <= arg_on;
            found_level <= LEVEL_W'(walk_idx);
            if (walk_last) begin
              arg_level <= ADDR_W'(walk_idx);
              kind      <= K_TAKE;
              state     <= S_RD;
            end else begin
              walk_idx <= walk_idx + AW'(1);
            end
          end else begin
            // final read fetches the duty of the chosen level
            arg_on    <= found_on;
            arg_level <= {1'b0, found_level};
            kind      <= K_TAKE;
            state     <= S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.status      = status;
  assign result.light_on    = is_on;
  assign result.light_level = cur_level;
  assign result.light_pwm   = PWM_FIELD_W'(cur_pwm);

endmodule

`default_nettype wire

// ===== design/dls_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dls_checker import dls_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire dls_out_t           result,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready,
  input wire logic [LEVEL_W-1:0] cfg_data
);

  // every accepted command keeps the block busy or finishes next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither busy nor done");

  // a result word only follows an accepted command
  a_done_has_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("done without a command in flight");

  // one result per command
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    (done && !(start && !busy)) |=> !done)
    else $error("extra result word");

  // failed step down reports a light that is off; failed step up one that is on
  a_status_state: assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.status != ST_OFF || !result.light_on) &&
              (result.status != ST_MAX || result.light_on)))
    else $error("status contradicts light state");

  // off level only changes between commands, with a known word
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> (!busy && !$isunknown(cfg_data)))
    else $error("config word taken while busy");

endmodule

bind dimmer_level_stepper_core dls_checker u_dls_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .result    (result),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data)
);

`default_nettype wire

// ===== bench/dimmer_state_checker.sv =====
`timescale 1ns / 1ps

// Watches the command, result and config channels of the dimmer core,
// predicts each result word and compares it with what comes out.
module dimmer_state_checker import dls_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire dls_in_t            cmd,
  input  wire logic               done,
  input  wire dls_out_t           result,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [LEVEL_W-1:0] cfg_data,
  output int                      mismatches,
  output int                      pending
);

  localparam int NUM_LEVELS = NUM_LEVELS_DEF;
  localparam logic [PWM_FIELD_W-1:0] PWM_MASK = PWM_FIELD_W'((1 << PWM_BITS_DEF) - 1);

  // shadow light state
  logic [PWM_FIELD_W-1:0] duty_tbl [0:NUM_LEVELS-1];
  logic                   lamp_on;
  logic [LEVEL_W-1:0]     lamp_level;
  logic [PWM_FIELD_W-1:0] lamp_pwm;
  logic [LEVEL_W-1:0]     off_lvl;

  dls_out_t expected_states[$];

  // reads past the table end give zero
  function automatic logic [PWM_FIELD_W-1:0] duty_at(int idx);
    if (idx >= NUM_LEVELS || idx < 0) return '0;
    return duty_tbl[idx];
  endfunction

  function automatic void settle(logic on, logic [LEVEL_W-1:0] lvl,
                                 logic [PWM_FIELD_W-1:0] pwm);
    lamp_on    = on;
    lamp_level = lvl;
    lamp_pwm   = pwm & PWM_MASK;
  endfunction

  // exact level/duty match stays; else last level before the first entry that is zero or > pwm, off if none
  function automatic void apply_duty(logic on, logic [LEVEL_W-1:0] lvl,
                                     logic [PWM_FIELD_W-1:0] pwm);
    logic               n_on;
    logic [LEVEL_W-1:0] n_lvl;
    logic               stop;
    if (pwm == duty_at(lvl)) begin
      settle(on, lvl, pwm);
      return;
    end
    n_on  = 1'b0;
    n_lvl = off_lvl;
    stop  = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (!stop) begin
        if (duty_tbl[i] == '0 || duty_tbl[i] > pwm) stop = 1'b1;
        else begin
          n_on  = on;
          n_lvl = i[LEVEL_W-1:0];
        end
      end
    end
    settle(n_on, n_lvl, duty_at(n_lvl));
  endfunction

  function automatic dls_out_t predict_light(dls_in_t w);
    dls_out_t               r;
    logic [1:0]             st;
    int                     nl;
    logic [PWM_FIELD_W-1:0] d;
    st = ST_OK;
    case (w.mode)
      MODE_TOGGLE: lamp_on = !lamp_on;
      MODE_UP: begin
        if (!lamp_on) settle(1'b1, '0, duty_at(0));
        else begin
          nl = int'(lamp_level) + 1;
          if (duty_at(nl) == '0) st = ST_MAX;
          else settle(1'b1, nl[LEVEL_W-1:0], duty_at(nl));
        end
      end
      MODE_DOWN: begin
        if (!lamp_on) st = ST_OFF;
        else if (lamp_level == '0) settle(1'b0, off_lvl, duty_at(off_lvl));
        else settle(1'b1, lamp_level - 1'b1, duty_at(int'(lamp_level) - 1));
      end
      MODE_SET: begin
        if (w.pwm_given) apply_duty(w.set_on, w.set_level, w.set_pwm & PWM_MASK);
        else begin
          d = duty_at(w.set_level);
          if (d == '0) st = ST_RANGE;
          else settle(w.set_on, w.set_level, d);
        end
      end
      MODE_WRITE: begin
        if (int'(w.table_index) < NUM_LEVELS)
          duty_tbl[w.table_index] = w.table_value & PWM_MASK;
      end
      MODE_REAPPLY:  apply_duty(lamp_on, lamp_level, lamp_pwm);
      MODE_DEFAULTS: settle(1'b0, off_lvl, duty_at(off_lvl));
      default: ;
    endcase
    r.status      = st;
    r.light_on    = lamp_on;
    r.light_level = lamp_level;
    r.light_pwm   = lamp_pwm;
    return r;
  endfunction

  always @(posedge clk) begin
    dls_out_t want;
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) duty_tbl[i] = '0;
      lamp_on    = 1'b0;
      lamp_level = '0;
      lamp_pwm   = '0;
      off_lvl    = '0;
      expected_states.delete();
      mismatches = 0;
    end else begin
      // result first: a new word may be taken in the same cycle
      if (done === 1'b1) begin
        if (expected_states.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word st=%0d on=%0d lvl=%0d pwm=%0d",
                     $time, result.status, result.light_on, result.light_level,
                     result.light_pwm);
        end else begin
          want = expected_states.pop_front();
          if (result.status !== want.status || result.light_on !== want.light_on ||
              result.light_level !== want.light_level ||
              result.light_pwm !== want.light_pwm) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch exp st=%0d on=%0d lvl=%0d pwm=%0d, got st=%0d on=%0d lvl=%0d pwm=%0d",
                       $time, want.status, want.light_on, want.light_level,
                       want.light_pwm, result.status, result.light_on,
                       result.light_level, result.light_pwm);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        expected_states.push_back(predict_light(cmd));
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
        off_lvl = cfg_data;
    end
    pending = expected_states.size();
  end

endmodule

// ===== bench/dimmer_level_stepper_core_tb.sv =====
`timescale 1ns / 1ps

module dimmer_level_stepper_core_tb;
  import dls_pkg::*;

  localparam logic [2:0] MODE_UNUSED = 3'd7;  // no-op code, reports state only

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  dls_in_t            cmd = '0;
  logic               done;
  dls_out_t           result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LEVEL_W-1:0] cfg_data = '0;

  int mismatch_count;
  int words_pending;

  // duties written so far, only to aim set-with-PWM at exact matches
  logic [PWM_FIELD_W-1:0] written_duty [0:255];
  bit no_gaps;      // phase runs back to back
  bit wide_levels;  // levels drawn over the whole range

  always #5 clk = ~clk;

  dimmer_level_stepper_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  dimmer_state_checker chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatch_count),
    .pending    (words_pending)
  );

  // Called at a falling edge; returns at the falling edge after acceptance.
  // With no gap, start stays high and the next word just replaces cmd.
  task automatic send_word(dls_in_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // unused fields carry random junk so every bit toggles
  function automatic dls_in_t blank_word(logic [2:0] m);
    logic [63:0] raw;
    dls_in_t     w;
    raw    = {$urandom, $urandom};
    w      = raw[$bits(dls_in_t)-1:0];
    w.mode = m;
    return w;
  endfunction

  task automatic do_op(logic [2:0] m);
    send_word(blank_word(m));
  endtask

  task automatic do_set(logic on, logic [LEVEL_W-1:0] lvl, logic [PWM_FIELD_W-1:0] pwm,
                        logic given);
    dls_in_t w;
    w           = blank_word(MODE_SET);
    w.set_on    = on;
    w.set_level = lvl;
    w.set_pwm   = pwm;
    w.pwm_given = given;
    send_word(w);
  endtask

  task automatic do_write(logic [LEVEL_W-1:0] idx, logic [PWM_FIELD_W-1:0] val);
    dls_in_t w;
    w             = blank_word(MODE_WRITE);
    w.table_index = idx;
    w.table_value = val;
    written_duty[idx] = val;
    send_word(w);
  endtask

  // Drop start and let every outstanding result come back.
  task automatic drain();
    start <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  // Only while idle; returns at a falling edge.
  task automatic write_off_level(logic [LEVEL_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_item();
    int                     pick;
    int                     idx;
    int                     v;
    logic [LEVEL_W-1:0]     lvl;
    logic [PWM_FIELD_W-1:0] pwm;
    pick = $urandom_range(0, 99);
    if (wide_levels || $urandom_range(0, 3) == 0) lvl = LEVEL_W'($urandom_range(0, 255));
    else lvl = LEVEL_W'($urandom_range(0, 15));
    if (pick < 18) begin
      // mostly rising duties over a short prefix, some holes and junk
      idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
      case ($urandom_range(0, 9))
        0:       v = 0;
        1:       v = $urandom_range(0, 1023);
        default: v = idx * 60 + $urandom_range(1, 59);
      endcase
      if (v > 1023) v = 1023;
      do_write(idx[LEVEL_W-1:0], v[PWM_FIELD_W-1:0]);
    end else if (pick < 40) begin
      case ($urandom_range(0, 3))
        0:       pwm = written_duty[lvl];
        1:       pwm = written_duty[LEVEL_W'($urandom_range(0, 15))] +
                       PWM_FIELD_W'($urandom_range(0, 3));
        default: pwm = PWM_FIELD_W'($urandom_range(0, 1023));
      endcase
      do_set(1'($urandom_range(0, 1)), lvl, pwm, 1'($urandom_range(0, 1)));
    end
    else if (pick < 55) do_op(MODE_UP);
    else if (pick < 67) do_op(MODE_DOWN);
    else if (pick < 75) do_op(MODE_TOGGLE);
    else if (pick < 88) do_op(MODE_REAPPLY);
    else if (pick < 95) do_op(MODE_DEFAULTS);
    else do_op(MODE_UNUSED);
  endtask

  initial begin
    logic [LEVEL_W-1:0] off_choice;
    for (int i = 0; i < 256; i++) written_duty[i] = '0;
    no_gaps     = 1'b0;
    wide_levels = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed part ----
    write_off_level(8'd2);
    do_op(MODE_DOWN);           // already off
    do_op(MODE_UP);             // off -> on at level 0, empty table
    do_op(MODE_UP);             // next entry zero: already at max
    do_set(1'b1, 8'd5, 10'd0, 1'b0);  // set to a zero-duty level: out of range
    do_write(8'd0, 10'd100);
    do_write(8'd1, 10'd200);
    do_write(8'd2, 10'd300);
    do_write(8'd3, 10'd1023);   // widest duty
    do_write(8'd255, 10'd1);    // top index, beyond the zero end marker
    do_set(1'b1, 8'd2, 10'd0, 1'b0);
    do_op(MODE_UP);
    do_op(MODE_UP);             // table ends at 4
    repeat (3) do_op(MODE_DOWN);
    do_op(MODE_DOWN);           // level 0 -> off at off level
    do_set(1'b1, 8'd3, 10'd1023, 1'b1);  // exact level/duty match
    do_set(1'b0, 8'd1, 10'd250, 1'b1);   // walk lands on level 1
    do_set(1'b1, 8'd0, 10'd50, 1'b1);    // nothing qualifies -> off
    do_set(1'b1, 8'd255, 10'd1023, 1'b1);
    do_op(MODE_TOGGLE);
    do_op(MODE_REAPPLY);        // exact match kept
    do_write(8'd0, 10'd0);
    do_write(8'd3, 10'd500);
    do_op(MODE_REAPPLY);        // table empty from 0 -> off
    do_op(MODE_DEFAULTS);
    do_op(MODE_UNUSED);

    // ---- random phases, off level swept incl. both extremes ----
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      repeat (2) @(negedge clk);
      case (ph)
        0, 4:    off_choice = 8'd255;
        1, 6:    off_choice = 8'd0;
        default: off_choice = LEVEL_W'($urandom_range(0, 255));
      endcase
      write_off_level(off_choice);
      no_gaps     = (ph == 3 || ph == 6);
      wide_levels = (ph == 2);
      if (ph == 2) begin
        // fill the whole table so walks and step-up reach the top
        for (int i = 0; i < 256; i++)
          do_write(i[LEVEL_W-1:0], PWM_FIELD_W'(i * 4 + $urandom_range(1, 3)));
        do_set(1'b1, 8'd255, 10'd0, 1'b0);
        do_op(MODE_UP);         // index past the table end
        do_op(MODE_REAPPLY);
      end
      repeat (240) rand_item();
    end

    drain();
    repeat (270) @(negedge clk);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
